@@ sv/gnbm_pkg.sv @@
// package: constants, types and helpers for the box-muller noise generator
package gnbm_pkg;

    localparam int UNIFORM_BITS_DEF = 32;
    localparam int DATA_W           = 32;

    localparam int LOG_STEPS = 26;
    localparam int RAD_W     = 32;
    localparam int SQ_SHIFT  = 14;
    localparam int REM_W     = RAD_W + SQ_SHIFT;
    localparam int MAG_W     = REM_W / 2;

    localparam int TRIG_TERMS = 7;
    localparam int SIN_TERMS  = 6;

    localparam int LOG_LAT   = LOG_STEPS + 2;
    localparam int SQRT_LAT  = MAG_W;
    localparam int TRIG_LAT  = 3 * TRIG_TERMS + 3;
    localparam int SCALE_LAT = 3;
    localparam int TRIG_DLY  = LOG_LAT + SQRT_LAT - TRIG_LAT;

    localparam logic [30:0] TWO_LN2_Q30    = 31'd1488522236;
    localparam logic [29:0] QUARTER_PI_Q30 = 30'd843314857;

    localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;
    localparam logic signed [31:0] HALF_Q30 = 32'sd536870912;

    localparam logic [31:0] MEAN_RST    = 32'd0;
    localparam logic [31:0] STD_DEV_RST = 32'd65536;

    localparam logic signed [37:0] SUM_MAX = 38'sd2147483647;
    localparam logic signed [37:0] SUM_MIN = -38'sd2147483648;
    localparam logic [31:0]        SAT_MAX = 32'h7fff_ffff;
    localparam logic [31:0]        SAT_MIN = 32'h8000_0000;

    typedef enum logic [0:0] {
        CFG_MEAN    = 1'b0,
        CFG_STD_DEV = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] zc;
        logic signed [31:0] zs;
    } trig_pair_t;

    function automatic logic [7:0] sin_div(input int k);
        int n;
        n = 2 + 2 * k;
        return 8'(n * (n + 1));
    endfunction

    function automatic logic [7:0] cos_div(input int k);
        int n;
        n = 1 + 2 * k;
        return 8'(n * (n + 1));
    endfunction

endpackage

@@ sv/gnbm_if.sv @@
// interfaces: uniform input channel, gaussian output channel, config write channel
interface gnbm_in_if import gnbm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] uniform_a;
    logic [DATA_W-1:0] uniform_b;

    modport source (output valid, output uniform_a, output uniform_b, input ready);
    modport sink (input valid, input uniform_a, input uniform_b, output ready);
endinterface

interface gnbm_out_if import gnbm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] normal_cos;
    logic [DATA_W-1:0] normal_sin;

    modport source (output valid, output normal_cos, output normal_sin, input ready);
    modport sink (input valid, input normal_cos, input normal_sin, output ready);
endinterface

interface gnbm_cfg_if import gnbm_pkg::*; ();
    logic              valid;
    logic              ready;
    cfg_index_t        index;
    logic [DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/gaussian_noise_box_muller.sv @@
// top level: box-muller gaussian noise generator
// throughput: one transaction per cycle while the output is not stalled, set by the 26
// squaring stages of the logarithm and the 23 root stages, each holding one transaction
// a zero first variate yields no result; a stalled output freezes every stage
// reset clears all valid bits, mean to 0 and std_dev to 1.0
module gaussian_noise_box_muller import gnbm_pkg::*;
#(
    parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    gnbm_in_if.sink        sample_in,
    gnbm_out_if.source     sample_out,
    gnbm_cfg_if.sink       cfg
);

    localparam int          EFF_BITS  = (UNIFORM_BITS > 32) ? 32 : UNIFORM_BITS;
    localparam logic [31:0] KEEP_MASK = ~((32'd1 << (32 - EFF_BITS)) - 32'd1);

    logic             en;
    logic [31:0]      a_red;
    logic [31:0]      b_red;
    logic             log_valid;
    logic [RAD_W-1:0] radicand;
    logic             mag_valid;
    logic [MAG_W-1:0] mag;
    trig_pair_t       trig;
    trig_pair_t       dly_reg [0:TRIG_DLY-1];
    logic [31:0]      mean_reg;
    logic [31:0]      std_dev_reg;

    assign en    = !sample_out.valid || sample_out.ready;
    assign a_red = sample_in.uniform_a & KEEP_MASK;
    assign b_red = sample_in.uniform_b & KEEP_MASK;

    assign sample_in.ready = en;
    assign cfg.ready       = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg    <= MEAN_RST;
            std_dev_reg <= STD_DEV_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_MEAN:    mean_reg    <= cfg.data;
                CFG_STD_DEV: std_dev_reg <= cfg.data;
            endcase
        end
    end

    gnbm_log u_log
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (sample_in.valid && (a_red != 32'd0)),
        .x         (a_red),
        .valid_out (log_valid),
        .radicand  (radicand)
    );

    gnbm_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (log_valid),
        .radicand  (radicand),
        .valid_out (mag_valid),
        .mag       (mag)
    );

    gnbm_trig u_trig
    (
        .clk   (clk),
        .en    (en),
        .angle (b_red),
        .trig  (trig)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= trig;
            for (int i = 1; i < TRIG_DLY; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    gnbm_scale u_scale
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .valid_in   (mag_valid),
        .mag        (mag),
        .trig       (dly_reg[TRIG_DLY-1]),
        .mean       (mean_reg),
        .std_dev    (std_dev_reg),
        .valid_out  (sample_out.valid),
        .normal_cos (sample_out.normal_cos),
        .normal_sin (sample_out.normal_sin)
    );

`ifndef SYNTHESIS
    // trig values stay within the unit range
    a_trig_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mag_valid |-> (dly_reg[TRIG_DLY-1].zc <= ONE_Q30 && dly_reg[TRIG_DLY-1].zc >= -ONE_Q30
                    && dly_reg[TRIG_DLY-1].zs <= ONE_Q30 && dly_reg[TRIG_DLY-1].zs >= -ONE_Q30))
        else $error("trig value out of range");

    // one of cos and sin is always large
    a_trig_norm: assert property (@(posedge clk) disable iff (!rst_n)
        mag_valid |-> (dly_reg[TRIG_DLY-1].zc >= HALF_Q30 || dly_reg[TRIG_DLY-1].zc <= -HALF_Q30
                    || dly_reg[TRIG_DLY-1].zs >= HALF_Q30 || dly_reg[TRIG_DLY-1].zs <= -HALF_Q30))
        else $error("trig pair lost its norm");

    // a held result freezes the input side
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        sample_out.valid && !sample_out.ready |-> !sample_in.ready)
        else $error("input taken while result stalled");
`endif

endmodule

@@ sv/gnbm_log.sv @@
// pipelined -log2 by repeated squaring, then scaling to -2 ln u1
module gnbm_log import gnbm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid_in,
    input  logic [31:0]      x,
    output logic             valid_out,
    output logic [RAD_W-1:0] radicand
);

    logic [31:0]          m_reg  [0:LOG_STEPS];
    logic [LOG_STEPS-1:0] f_reg  [0:LOG_STEPS];
    logic [5:0]           ip_reg [0:LOG_STEPS];
    logic                 v_reg  [0:LOG_STEPS];
    logic [4:0]           e_next;
    logic [31:0]          l_next;
    logic [63:0]          prod_next;
    logic [RAD_W-1:0]     rad_reg;
    logic                 vout_reg;

    always_comb
    begin
        e_next = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
            begin
                e_next = 5'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0]  <= x << (5'd31 - e_next);
            f_reg[0]  <= '0;
            ip_reg[0] <= 6'd32 - {1'b0, e_next};
        end
    end

    for (genvar j = 1; j <= LOG_STEPS; j++)
    begin : g_sq
        logic [63:0] sq_next;

        assign sq_next = 64'(m_reg[j-1]) * 64'(m_reg[j-1]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (sq_next[63])
                begin
                    m_reg[j] <= sq_next[63:32];
                end
                else
                begin
                    m_reg[j] <= sq_next[62:31];
                end
                f_reg[j]  <= {f_reg[j-1][LOG_STEPS-2:0], sq_next[63]};
                ip_reg[j] <= ip_reg[j-1];
            end
        end
    end

    assign l_next    = (32'(ip_reg[LOG_STEPS]) << LOG_STEPS) - 32'(f_reg[LOG_STEPS]);
    assign prod_next = 64'(l_next) * 64'(TWO_LN2_Q30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout_reg <= 1'b0;
        end
        else if (en)
        begin
            vout_reg <= v_reg[LOG_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= prod_next[61:30];
        end
    end

    assign valid_out = vout_reg;
    assign radicand  = rad_reg;

endmodule

@@ sv/gnbm_sqrt.sv @@
// pipelined integer square root, one result bit per stage
module gnbm_sqrt import gnbm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid_in,
    input  logic [RAD_W-1:0] radicand,
    output logic             valid_out,
    output logic [MAG_W-1:0] mag
);

    logic [REM_W-1:0] rem_reg  [0:MAG_W-1];
    logic [MAG_W-1:0] root_reg [0:MAG_W-1];
    logic             v_reg    [0:MAG_W-1];

    for (genvar k = 0; k < MAG_W; k++)
    begin : g_bit
        localparam int BIT = MAG_W - 1 - k;

        logic [REM_W-1:0] rem_in;
        logic [MAG_W-1:0] root_in;
        logic             v_in;
        logic [REM_W-1:0] trial_next;

        if (k == 0)
        begin : g_first
            assign rem_in  = {radicand, {SQ_SHIFT{1'b0}}};
            assign root_in = '0;
            assign v_in    = valid_in;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign v_in    = v_reg[k-1];
        end

        assign trial_next = (REM_W'(root_in) << (BIT + 1)) + (REM_W'(1) << (2 * BIT));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= trial_next)
                begin
                    rem_reg[k]  <= rem_in - trial_next;
                    root_reg[k] <= root_in | (MAG_W'(1) << BIT);
                end
                else
                begin
                    rem_reg[k]  <= rem_in;
                    root_reg[k] <= root_in;
                end
            end
        end
    end

    assign valid_out = v_reg[MAG_W-1];
    assign mag       = root_reg[MAG_W-1];

endmodule

@@ sv/gnbm_trig.sv @@
// pipelined sine and cosine by octant folding and taylor series
module gnbm_trig import gnbm_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] angle,
    output trig_pair_t  trig
);

    typedef struct packed {
        logic [2:0]         oct;
        logic [29:0]        x2;
        logic [30:0]        term_s;
        logic [30:0]        term_c;
        logic signed [31:0] sum_s;
        logic signed [31:0] sum_c;
        logic [29:0]        p_s;
        logic [29:0]        p_c;
        logic [29:0]        q_s;
        logic [29:0]        q_c;
    } trig_slot_t;

    function automatic logic [29:0] mul_q30(input logic [30:0] a, input logic [29:0] b);
        logic [60:0] pr;
        pr = 61'(a) * 61'(b);
        return pr[59:30];
    endfunction

    function automatic logic [29:0] mul_rcp(input logic [29:0] p, input logic [31:0] rcp);
        logic [61:0] pr;
        pr = 62'(p) * 62'(rcp);
        return pr[61:32];
    endfunction

    function automatic logic [29:0] fix_q(input logic [29:0] p, input logic [29:0] q0,
                                          input logic [7:0] d);
        logic [37:0] qd;
        logic [29:0] rem;
        qd  = 38'(q0) * 38'(d);
        rem = p - qd[29:0];
        return (rem >= 30'(d)) ? q0 + 30'd1 : q0;
    endfunction

    logic [29:0] r_next;
    logic [59:0] t_prod;
    logic [29:0] t_reg;
    logic [2:0]  oct_reg;
    logic [59:0] x2_prod;
    trig_slot_t  st_reg [0:3*TRIG_TERMS];
    trig_pair_t  trig_reg;

    assign r_next = angle[29] ? (30'd1 << 29) - {1'b0, angle[28:0]} : {1'b0, angle[28:0]};
    assign t_prod = 60'(r_next) * 60'(QUARTER_PI_Q30);
    assign x2_prod = 60'(t_reg) * 60'(t_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg   <= t_prod[58:29];
            oct_reg <= angle[31:29];
            st_reg[0].oct    <= oct_reg;
            st_reg[0].x2     <= x2_prod[59:30];
            st_reg[0].term_s <= {1'b0, t_reg};
            st_reg[0].term_c <= 31'(ONE_Q30);
            st_reg[0].sum_s  <= $signed({2'b00, t_reg});
            st_reg[0].sum_c  <= ONE_Q30;
            st_reg[0].p_s    <= '0;
            st_reg[0].p_c    <= '0;
            st_reg[0].q_s    <= '0;
            st_reg[0].q_c    <= '0;
        end
    end

    for (genvar k = 0; k < TRIG_TERMS; k++)
    begin : g_term
        localparam logic [7:0]  DIV_S = sin_div(k);
        localparam logic [7:0]  DIV_C = cos_div(k);
        localparam logic [31:0] RCP_S = 32'(64'h1_0000_0000 / 64'(DIV_S));
        localparam logic [31:0] RCP_C = 32'(64'h1_0000_0000 / 64'(DIV_C));
        localparam bit          SUB   = (k % 2 == 0);
        localparam bit          DO_S  = (k < SIN_TERMS);

        trig_slot_t a_next;
        trig_slot_t b_next;
        trig_slot_t c_next;
        logic [29:0] qs_fix;
        logic [29:0] qc_fix;

        always_comb
        begin
            a_next     = st_reg[3*k];
            a_next.p_c = mul_q30(a_next.term_c, a_next.x2);
            if (DO_S)
            begin
                a_next.p_s = mul_q30(a_next.term_s, a_next.x2);
            end
        end

        always_comb
        begin
            b_next     = st_reg[3*k+1];
            b_next.q_c = mul_rcp(b_next.p_c, RCP_C);
            if (DO_S)
            begin
                b_next.q_s = mul_rcp(b_next.p_s, RCP_S);
            end
        end

        assign qc_fix = fix_q(st_reg[3*k+2].p_c, st_reg[3*k+2].q_c, DIV_C);
        assign qs_fix = fix_q(st_reg[3*k+2].p_s, st_reg[3*k+2].q_s, DIV_S);

        always_comb
        begin
            c_next        = st_reg[3*k+2];
            c_next.term_c = {1'b0, qc_fix};
            if (SUB)
            begin
                c_next.sum_c = c_next.sum_c - $signed({2'b00, qc_fix});
            end
            else
            begin
                c_next.sum_c = c_next.sum_c + $signed({2'b00, qc_fix});
            end
            if (DO_S)
            begin
                c_next.term_s = {1'b0, qs_fix};
                if (SUB)
                begin
                    c_next.sum_s = c_next.sum_s - $signed({2'b00, qs_fix});
                end
                else
                begin
                    c_next.sum_s = c_next.sum_s + $signed({2'b00, qs_fix});
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[3*k+1] <= a_next;
                st_reg[3*k+2] <= b_next;
                st_reg[3*k+3] <= c_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (st_reg[3*TRIG_TERMS].oct)
                3'd0:
                begin
                    trig_reg.zc <= st_reg[3*TRIG_TERMS].sum_c;
                    trig_reg.zs <= st_reg[3*TRIG_TERMS].sum_s;
                end
                3'd1:
                begin
                    trig_reg.zc <= st_reg[3*TRIG_TERMS].sum_s;
                    trig_reg.zs <= st_reg[3*TRIG_TERMS].sum_c;
                end
                3'd2:
                begin
                    trig_reg.zc <= -st_reg[3*TRIG_TERMS].sum_s;
                    trig_reg.zs <= st_reg[3*TRIG_TERMS].sum_c;
                end
                3'd3:
                begin
                    trig_reg.zc <= -st_reg[3*TRIG_TERMS].sum_c;
                    trig_reg.zs <= st_reg[3*TRIG_TERMS].sum_s;
                end
                3'd4:
                begin
                    trig_reg.zc <= -st_reg[3*TRIG_TERMS].sum_c;
                    trig_reg.zs <= -st_reg[3*TRIG_TERMS].sum_s;
                end
                3'd5:
                begin
                    trig_reg.zc <= -st_reg[3*TRIG_TERMS].sum_s;
                    trig_reg.zs <= -st_reg[3*TRIG_TERMS].sum_c;
                end
                3'd6:
                begin
                    trig_reg.zc <= st_reg[3*TRIG_TERMS].sum_s;
                    trig_reg.zs <= -st_reg[3*TRIG_TERMS].sum_c;
                end
                3'd7:
                begin
                    trig_reg.zc <= st_reg[3*TRIG_TERMS].sum_c;
                    trig_reg.zs <= -st_reg[3*TRIG_TERMS].sum_s;
                end
            endcase
        end
    end

    assign trig = trig_reg;

endmodule

@@ sv/gnbm_scale.sv @@
// output stages: magnitude times trig, std_dev scaling, mean offset and saturation
module gnbm_scale import gnbm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid_in,
    input  logic [MAG_W-1:0] mag,
    input  trig_pair_t       trig,
    input  logic [31:0]      mean,
    input  logic [31:0]      std_dev,
    output logic             valid_out,
    output logic [31:0]      normal_cos,
    output logic [31:0]      normal_sin
);

    logic signed [31:0] tv [0:1];
    logic [23:0]        m1_reg   [0:1];
    logic               neg1_reg [0:1];
    logic [35:0]        p_reg    [0:1];
    logic               neg2_reg [0:1];
    logic [31:0]        res_reg  [0:1];
    logic               v_reg    [0:SCALE_LAT-1];

    assign tv[0] = trig.zc;
    assign tv[1] = trig.zs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
            v_reg[1] <= 1'b0;
            v_reg[2] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= valid_in;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
        end
    end

    for (genvar b = 0; b < 2; b++)
    begin : g_branch
        logic [31:0]        abs_next;
        logic [53:0]        m1_next;
        logic [55:0]        p_next;
        logic signed [37:0] mu_next;
        logic signed [37:0] pv_next;
        logic signed [37:0] sum_next;

        assign abs_next = tv[b][31] ? 32'(-tv[b]) : 32'(tv[b]);
        assign m1_next  = 54'(mag) * 54'(abs_next[30:0]);
        assign p_next   = 56'(m1_reg[b]) * 56'(std_dev);
        assign mu_next  = $signed({{6{mean[31]}}, mean});
        assign pv_next  = $signed({2'b00, p_reg[b]});
        assign sum_next = neg2_reg[b] ? mu_next - pv_next : mu_next + pv_next;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m1_reg[b]   <= m1_next[53:30];
                neg1_reg[b] <= tv[b][31];
                p_reg[b]    <= p_next[55:20];
                neg2_reg[b] <= neg1_reg[b];
                if (sum_next > SUM_MAX)
                begin
                    res_reg[b] <= SAT_MAX;
                end
                else if (sum_next < SUM_MIN)
                begin
                    res_reg[b] <= SAT_MIN;
                end
                else
                begin
                    res_reg[b] <= sum_next[31:0];
                end
            end
        end
    end

    assign valid_out  = v_reg[SCALE_LAT-1];
    assign normal_cos = res_reg[0];
    assign normal_sin = res_reg[1];

endmodule

@@ tb/gnbm_tb_checker.sv @@
// checker: predicts gaussian samples from uniform transactions and compares results
`timescale 1ns / 100ps
module gnbm_tb_checker import gnbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    gnbm_in_if.sink    mon_in,
    gnbm_out_if.sink   mon_out,
    gnbm_cfg_if.sink   mon_cfg,
    output int         fail_count,
    output int         pending_count,
    output int         result_count
);

    typedef struct {
        logic [31:0] zcos;
        logic [31:0] zsin;
    } gauss_pair_t;

    gauss_pair_t sample_q[$];
    logic [31:0] mean_reg;
    logic [31:0] sdev_reg;

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] neg_log2(input logic [31:0] x);
        int e;
        logic [63:0] m;
        logic [63:0] f;
        e = 31;
        f = 0;
        while (e > 0 && x[e] == 1'b0)
            e--;
        m = 64'(x) << (31 - e);
        for (int i = 0; i < 26; i++)
        begin
            m = (m * m) >> 31;
            f = f << 1;
            if (m >= (64'd1 << 32))
            begin
                f = f | 1;
                m = m >> 1;
            end
        end
        return (64'(32 - e) << 26) - f;
    endfunction

    function automatic longint taylor(input logic [63:0] start, input logic [63:0] x2,
                                      input logic [63:0] n0, input int count);
        longint sum;
        logic [63:0] term;
        logic [63:0] n;
        sum = longint'(start);
        term = start;
        n = n0;
        for (int i = 0; i < count; i++)
        begin
            term = ((term * x2) >> 30) / (n * (n + 1));
            if (i & 1)
                sum = sum + longint'(term);
            else
                sum = sum - longint'(term);
            n = n + 2;
        end
        return sum;
    endfunction

    function automatic logic [31:0] scale_branch(input logic [63:0] mag, input longint trig);
        logic [63:0] a;
        logic [63:0] m1;
        longint p;
        longint v;
        a = (trig < 0) ? 64'(-trig) : 64'(trig);
        m1 = (mag * a) >> 30;
        p = longint'((m1 * 64'(sdev_reg)) >> 20);
        v = longint'(signed'(mean_reg)) + ((trig < 0) ? -p : p);
        if (v > 64'sd2147483647)
            return SAT_MAX;
        if (v < -64'sd2147483648)
            return SAT_MIN;
        return v[31:0];
    endfunction

    function automatic gauss_pair_t predict_pair(input logic [31:0] ua, input logic [31:0] ub);
        gauss_pair_t res;
        logic [63:0] lg;
        logic [63:0] rad;
        logic [63:0] mag;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] x2;
        longint s;
        longint c;
        longint zc;
        longint zs;
        logic [2:0] oct;
        lg = neg_log2(ua);
        rad = (lg * 64'd1488522236) >> 30;
        mag = root64(rad << 14);
        oct = ub[31:29];
        r = 64'(ub[28:0]);
        if (oct[0])
            r = (64'd1 << 29) - r;
        t = (r * 64'd843314857) >> 29;
        x2 = (t * t) >> 30;
        s = taylor(t, x2, 2, 6);
        c = taylor(64'd1 << 30, x2, 1, 7);
        case (oct)
            3'd0: begin zc = c;  zs = s;  end
            3'd1: begin zc = s;  zs = c;  end
            3'd2: begin zc = -s; zs = c;  end
            3'd3: begin zc = -c; zs = s;  end
            3'd4: begin zc = -c; zs = -s; end
            3'd5: begin zc = -s; zs = -c; end
            3'd6: begin zc = s;  zs = -c; end
            default: begin zc = c; zs = -s; end
        endcase
        res.zcos = scale_branch(mag, zc);
        res.zsin = scale_branch(mag, zs);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        gauss_pair_t want;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            mean_reg <= MEAN_RST;
            sdev_reg <= STD_DEV_RST;
            fail_count <= 0;
            result_count <= 0;
            pending_count <= 0;
            sample_q.delete();
        end
        else
        begin
            if (mon_cfg.valid && mon_cfg.ready)
            begin
                if (mon_cfg.index == CFG_MEAN)
                    mean_reg <= mon_cfg.data;
                else if (mon_cfg.index == CFG_STD_DEV)
                    sdev_reg <= mon_cfg.data;
            end
            if (mon_in.valid && mon_in.ready && mon_in.uniform_a != 0)
                sample_q.insert(sample_q.size(),
                                predict_pair(mon_in.uniform_a, mon_in.uniform_b));
            if (mon_out.valid && mon_out.ready)
            begin
                result_count <= result_count + 1;
                if (sample_q.size() == 0)
                begin
                    $error("unexpected transaction cos=%h sin=%h",
                           mon_out.normal_cos, mon_out.normal_sin);
                    errs = errs + 1;
                end
                else
                begin
                    want = sample_q.pop_front();
                    if (want.zcos !== mon_out.normal_cos)
                    begin
                        $error("normal_cos expected %h actual %h", want.zcos,
                               mon_out.normal_cos);
                        errs = errs + 1;
                    end
                    if (want.zsin !== mon_out.normal_sin)
                    begin
                        $error("normal_sin expected %h actual %h", want.zsin,
                               mon_out.normal_sin);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending_count <= sample_q.size();
        end
    end

endmodule

@@ tb/gaussian_noise_box_muller_tb.sv @@
// testbench top: drives uniform and config transactions, gives the verdict
`timescale 1ns / 100ps
module gaussian_noise_box_muller_tb;
    import gnbm_pkg::*;

    localparam int LATENCY = 54;
    localparam int N_RANDOM = 800;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    int fail_count;
    int pending_count;
    int result_count;
    int accepted_count;
    int zero_count;
    longint cycle_count;
    bit hold_sink;
    bit drain_done;

    gnbm_in_if  sample_in ();
    gnbm_out_if sample_out ();
    gnbm_cfg_if cfg ();

    gaussian_noise_box_muller u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in.sink),
        .sample_out (sample_out.source),
        .cfg        (cfg.sink)
    );

    gnbm_tb_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .mon_in        (sample_in.sink),
        .mon_out       (sample_out.sink),
        .mon_cfg       (cfg.sink),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("gaussian_noise_box_muller test failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // output side: random stalls, plus a long forced hold
    initial
    begin
        int g;
        sample_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                sample_out.ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_sink = 1'b0;
            end
            g = drain_done ? 0 : gap_len();
            if (g > 0)
            begin
                sample_out.ready <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
            else
                sample_out.ready <= 1'b1;
        end
    end

    task automatic send_uniform(input logic [31:0] ua, input logic [31:0] ub, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            sample_in.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        sample_in.valid <= 1'b1;
        sample_in.uniform_a <= ua;
        sample_in.uniform_b <= ub;
        @(posedge clk);
        while (!sample_in.ready)
            @(posedge clk);
        accepted_count++;
        if (ua == 0)
            zero_count++;
        @(negedge clk);
    endtask

    task automatic drain();
        sample_in.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic random_burst(input int n);
        logic [31:0] ua;
        int p;
        for (int i = 0; i < n; i++)
        begin
            p = $urandom_range(0, 99);
            ua = $urandom();
            if (p < 5)
                ua = 0;
            else if (p < 15)
                ua = ua >> $urandom_range(1, 31);
            else if (p < 20)
                ua = ua | 32'hffff_0000;
            if (p > 5 && ua == 0)
                ua = 1;
            send_uniform(ua, $urandom(), 1'b1);
        end
    endtask

    initial
    begin
        logic [31:0] means[5];
        logic [31:0] sdevs[5];
        sample_in.valid = 1'b0;
        sample_in.uniform_a = '0;
        sample_in.uniform_b = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_MEAN;
        cfg.data = '0;
        cycle_count = 0;
        accepted_count = 0;
        zero_count = 0;
        hold_sink = 1'b0;
        drain_done = 1'b0;
        means = '{32'd0, 32'h7fff_ffff, 32'h8000_0000, 32'hfffe_8000, 32'h0003_4000};
        sdevs = '{32'd65536, 32'hffff_ffff, 32'd0, 32'd1, 32'h0002_8000};
        @(posedge rst_n);
        @(negedge clk);

        // reset configuration, edge variates
        send_uniform(32'd0, 32'h1234_5678, 1'b0);
        send_uniform(32'd1, 32'd0, 1'b0);
        send_uniform(32'hffff_ffff, 32'hffff_ffff, 1'b0);
        send_uniform(32'h8000_0000, 32'h2000_0000, 1'b0);
        send_uniform(32'h0000_0001, 32'h1fff_ffff, 1'b0);
        for (int k = 0; k < 8; k++)
            send_uniform(32'h0000_0100 << k, 32'(k) << 29, 1'b0);
        send_uniform(32'd0, 32'hffff_ffff, 1'b0);
        send_uniform(32'h5555_5555, 32'haaaa_aaaa, 1'b0);
        send_uniform(32'haaaa_aaaa, 32'h5555_5555, 1'b0);
        drain();

        // long output hold while input keeps offering
        hold_sink = 1'b1;
        random_burst(120);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(CFG_MEAN, means[ph]);
            write_reg(CFG_STD_DEV, sdevs[ph]);
            send_uniform(32'd1, 32'h0000_0000, 1'b0);
            send_uniform(32'd1, 32'h8000_0000, 1'b0);
            send_uniform(32'hffff_ffff, 32'h4000_0000, 1'b0);
            random_burst(N_RANDOM / 5 - 24);
            drain();
        end

        drain_done = 1'b1;
        drain();
        $display("covered %0d uniform transactions (%0d rejected), %0d results checked",
                 accepted_count, zero_count, result_count);
        $display("five mean/std_dev settings including saturating extremes");
        if (fail_count == 0 && pending_count == 0)
            $display("gaussian_noise_box_muller test passed");
        else
            $display("gaussian_noise_box_muller test failed");
        $finish;
    end

endmodule
